### rtl/stkl_pkg.sv
// types and constants shared by the sorted top-k list unit
`default_nettype none

package stkl_pkg;

    localparam int PAT_W    = 16;
    localparam int TAG_W    = 8;
    localparam int SCORE_W  = 3;
    localparam int ZONE_N   = 4;
    localparam int ZMAP_W   = 32;
    localparam int CAP_W    = 5;
    localparam int RIDX_W   = 4;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 3'd4;

    localparam logic [PAT_W-1:0]  REF_RST  = 16'd12957;
    localparam logic [ZMAP_W-1:0] ZMAP_RST = 32'd3012960132;
    localparam logic [CAP_W-1:0]  CAP_RST  = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_REF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZMAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 2'd2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        t_cmd               command;
        logic [PAT_W-1:0]   pattern;
        logic [TAG_W-1:0]   tag;
        logic [RIDX_W-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic [POS_W-1:0]   position;
        logic [SCORE_W-1:0] score;
        logic [CNT_W-1:0]   list_size;
        logic [CNT_W-1:0]   perfect_count;
        logic               entry_valid;
        logic [PAT_W-1:0]   entry_pattern;
        logic [TAG_W-1:0]   entry_tag;
        logic [SCORE_W-1:0] entry_score;
    } t_out_item;

    typedef struct packed {
        logic ins;
        logic valid;
        logic tail;
        logic last;
        logic grow;
    } t_cell_ctl;

    typedef struct packed {
        logic slot;
        logic first;
        logic drop4;
    } t_cell_stat;

endpackage

`default_nettype wire

### rtl/stkl_in_if.sv
// input channel of the sorted top-k list unit
`default_nettype none

interface stkl_in_if;
    logic               valid;
    logic               ready;
    stkl_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/stkl_out_if.sv
// result channel of the sorted top-k list unit
`default_nettype none

interface stkl_out_if;
    logic                valid;
    logic                ready;
    stkl_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/stkl_score.sv
// zone match scoring of one pattern against the reference
`default_nettype none

module stkl_score (
    input  wire logic [stkl_pkg::PAT_W-1:0]   i_pattern,
    input  wire logic [stkl_pkg::PAT_W-1:0]   i_ref,
    input  wire logic [stkl_pkg::ZMAP_W-1:0]  i_zone_map,
    output logic      [stkl_pkg::SCORE_W-1:0] o_score
);

    logic [stkl_pkg::PAT_W-1:0]  diff;
    logic [stkl_pkg::ZONE_N-1:0] failed;

    assign diff = i_pattern ^ i_ref;

    always_comb begin
        failed = '0;
        for (int z = 0; z < stkl_pkg::ZONE_N; z++) begin
            for (int b = 0; b < stkl_pkg::PAT_W; b++) begin
                if (diff[b] && (i_zone_map[2*b +: 2] == 2'(z))) begin
                    failed[z] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_score = '0;
        for (int z = 0; z < stkl_pkg::ZONE_N; z++) begin
            o_score = o_score + stkl_pkg::SCORE_W'(!failed[z]);
        end
    end

endmodule

`default_nettype wire

### rtl/stkl_cell.sv
// one list cell: holds an entry, takes the new entry or its upper neighbor
`default_nettype none

module stkl_cell (
    input  wire logic                           i_clk,
    input  wire stkl_pkg::t_cell_ctl            i_ctl,
    input  wire logic                           i_shift_in,
    input  wire stkl_pkg::t_entry               i_new,
    input  wire stkl_pkg::t_entry               i_prev,
    output stkl_pkg::t_entry                    o_entry,
    output stkl_pkg::t_cell_stat                o_stat
);

    stkl_pkg::t_entry r_entry;
    logic             slot;

    assign slot = (i_ctl.valid && (i_new.score > r_entry.score)) ||
                  (i_ctl.tail && i_ctl.grow);

    assign o_stat.slot  = slot;
    assign o_stat.first = slot && !i_shift_in;
    assign o_stat.drop4 = i_ctl.last && (r_entry.score == stkl_pkg::SCORE_MAX);
    assign o_entry      = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_shift_in) begin
                r_entry <= i_prev;
            end else if (slot) begin
                r_entry <= i_new;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/scored_topk_sorted_list_unit.sv
// top level of the sorted top-k list unit: cell row, scoring, counters, result register
// each accepted beat's result is registered into the output register
// one item per cycle when not stalled; all cells compare and shift in the same cycle
// a result waiting in the output register does not stop the next beat if it is taken
// reset: sync, active low; clears size, perfect count and result valid, presets config
// list contents are not cleared and are only read below the current size
`default_nettype none

module scored_topk_sorted_list_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [stkl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [stkl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    stkl_in_if.sink                                 i_in,
    stkl_out_if.source                              o_out
);

    localparam int UW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = (UW > stkl_pkg::CAP_W) ? UW : stkl_pkg::CAP_W;
    localparam int NR = (DEPTH < (1 << stkl_pkg::RIDX_W)) ? DEPTH : (1 << stkl_pkg::RIDX_W);

    logic [stkl_pkg::PAT_W-1:0]  r_ref;
    logic [stkl_pkg::ZMAP_W-1:0] r_zmap;
    logic [stkl_pkg::CAP_W-1:0]  r_cap;
    logic [UW-1:0]               r_used;
    logic [UW-1:0]               r_perfect;
    logic                        r_ovalid;
    stkl_pkg::t_out_item         r_out;

    logic [UW-1:0]               n_used;
    logic [UW-1:0]               n_perfect;
    stkl_pkg::t_out_item         n_out;

    logic                        in_fire;
    logic                        is_ins;
    logic                        is_read;
    logic [CW-1:0]               cap_raw;
    logic [CW-1:0]               cap_eff;
    logic                        grow;
    logic [stkl_pkg::SCORE_W-1:0] new_score;
    stkl_pkg::t_entry            new_entry;

    stkl_pkg::t_entry            cell_entry [DEPTH];
    stkl_pkg::t_cell_stat        cell_stat  [DEPTH];
    logic [DEPTH-1:0]            slot_vec;
    logic [DEPTH-1:0]            first_vec;
    logic [DEPTH-1:0]            drop_vec;
    logic                        any_slot;
    logic [PW-1:0]               pos_enc;
    logic                        rd_valid;
    stkl_pkg::t_entry            rd_entry;

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = !r_ovalid || o_out.ready;
    assign is_ins  = in_fire && (i_in.data.command == stkl_pkg::CMD_INSERT);
    assign is_read = i_in.data.command == stkl_pkg::CMD_READ;

    // usable capacity, clamped to 1..DEPTH
    assign cap_raw = CW'(r_cap);
    always_comb begin
        cap_eff = cap_raw;
        if (cap_raw == '0) begin
            cap_eff = CW'(1);
        end else if (cap_raw > CW'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end
    end
    assign grow = CW'(r_used) < cap_eff;

    stkl_score u_score (
        .i_pattern  (i_in.data.pattern),
        .i_ref      (r_ref),
        .i_zone_map (r_zmap),
        .o_score    (new_score)
    );

    assign new_entry.pattern = i_in.data.pattern;
    assign new_entry.tag     = i_in.data.tag;
    assign new_entry.score   = new_score;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        stkl_pkg::t_cell_ctl ctl;
        logic                shift_in;
        stkl_pkg::t_entry    prev;

        assign ctl.ins   = is_ins;
        assign ctl.valid = UW'(g) < r_used;
        assign ctl.tail  = r_used == UW'(g);
        assign ctl.last  = r_used == UW'(g + 1);
        assign ctl.grow  = grow;

        if (g == 0) begin : g_head
            assign shift_in = 1'b0;
            assign prev     = new_entry;
        end else begin : g_body
            assign shift_in = cell_stat[g-1].slot;
            assign prev     = cell_entry[g-1];
        end

        stkl_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_shift_in (shift_in),
            .i_new      (new_entry),
            .i_prev     (prev),
            .o_entry    (cell_entry[g]),
            .o_stat     (cell_stat[g])
        );

        assign slot_vec[g]  = cell_stat[g].slot;
        assign first_vec[g] = cell_stat[g].first;
        assign drop_vec[g]  = cell_stat[g].drop4;
    end

    assign any_slot = |slot_vec;

    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first_vec[i]) begin
                pos_enc = pos_enc | PW'(i);
            end
        end
    end

    // read port reaches the first entries only, as far as the index field goes
    assign rd_valid = CW'(i_in.data.read_index) < CW'(r_used);
    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < NR; i++) begin
            if (i_in.data.read_index == stkl_pkg::RIDX_W'(i)) begin
                rd_entry = cell_entry[i];
            end
        end
    end

    always_comb begin
        n_used    = r_used;
        n_perfect = r_perfect;
        if (!is_read && any_slot) begin
            if (grow) begin
                n_used = r_used + UW'(1);
            end else if (|drop_vec) begin
                n_perfect = n_perfect - UW'(1);
            end
            if (new_score == stkl_pkg::SCORE_MAX) begin
                n_perfect = n_perfect + UW'(1);
            end
        end
    end

    always_comb begin
        n_out = '0;
        n_out.list_size     = stkl_pkg::CNT_W'(n_used);
        n_out.perfect_count = stkl_pkg::CNT_W'(n_perfect);
        if (!is_read) begin
            n_out.accepted = any_slot;
            n_out.score    = new_score;
            if (any_slot) begin
                n_out.position = stkl_pkg::POS_W'(pos_enc);
            end
        end else if (rd_valid) begin
            n_out.entry_valid   = 1'b1;
            n_out.entry_pattern = rd_entry.pattern;
            n_out.entry_tag     = rd_entry.tag;
            n_out.entry_score   = rd_entry.score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref     <= stkl_pkg::REF_RST;
            r_zmap    <= stkl_pkg::ZMAP_RST;
            r_cap     <= stkl_pkg::CAP_RST;
            r_used    <= '0;
            r_perfect <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    stkl_pkg::CFG_REF: begin
                        r_ref <= i_cfg_wdata[stkl_pkg::PAT_W-1:0];
                    end
                    stkl_pkg::CFG_ZMAP: begin
                        r_zmap <= i_cfg_wdata[stkl_pkg::ZMAP_W-1:0];
                    end
                    stkl_pkg::CFG_CAP: begin
                        r_cap <= i_cfg_wdata[stkl_pkg::CAP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_used    <= n_used;
                r_perfect <= n_perfect;
                r_ovalid  <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    a_perfect_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_perfect <= r_used)
        else $error("perfect count above list size");

    a_used_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(DEPTH))
        else $error("list size above depth");

    a_one_insert_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(first_vec))
        else $error("more than one insert point");

    a_grow_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_ins && any_slot && grow |=> r_used == $past(r_used) + UW'(1))
        else $error("growing insert did not bump the size");

    a_read_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && is_read |=> r_used == $past(r_used) && r_perfect == $past(r_perfect))
        else $error("read beat changed the list counters");

endmodule

`default_nettype wire
